// ----- design/sfr_pkg.sv -----
// Shared types, codes and constants of the serial frame receiver.
`default_nettype none

package sfr_pkg;

  localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
  localparam logic [7:0]  SUM_GOOD      = 8'hFF;
  localparam logic [15:0] RECV_BASE     = 16'd100;
  localparam logic [5:0]  MAX_RECEIVERS = 6'd32;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_PAYLOAD = 3'd0,
    CFG_NEGO_TOPIC  = 3'd1,
    CFG_TIME_TOPIC  = 3'd2,
    CFG_PARAM_TOPIC = 3'd3,
    CFG_RECV_COUNT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_SYNC1    = 3'd0,
    ST_SYNC2    = 3'd1,
    ST_TOPIC_LO = 3'd2,
    ST_TOPIC_HI = 3'd3,
    ST_LEN_LO   = 3'd4,
    ST_LEN_HI   = 3'd5,
    ST_PAYLOAD  = 3'd6,
    ST_SUM      = 3'd7
  } parse_state_e;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_CSUM_BAD = 3'd1,
    STAT_TOO_BIG  = 3'd2,
    STAT_SYNC_ERR = 3'd3,
    STAT_UNKNOWN  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CLS_NEGO  = 3'd0,
    CLS_TIME  = 3'd1,
    CLS_PARAM = 3'd2,
    CLS_RECV  = 3'd3,
    CLS_OTHER = 3'd4
  } topic_class_e;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_EVENT   = 1'b1;

  typedef struct packed {
    logic [15:0] max_payload;
    logic [15:0] nego_topic;
    logic [15:0] time_topic;
    logic [15:0] param_topic;
    logic [5:0]  recv_count;
  } sfr_cfg_t;

  typedef struct packed {
    logic         kind;
    logic [7:0]   data_byte;
    logic [15:0]  byte_index;
    logic [15:0]  topic;
    logic [15:0]  payload_length;
    status_e      status;
    topic_class_e topic_class;
    logic [4:0]   receiver_slot;
  } sfr_result_t;

endpackage

`default_nettype wire

// ----- design/sfr_parser.sv -----
// Input register and frame parser state machine with topic classification.
`default_nettype none

module sfr_parser
  import sfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic [7:0]  in_byte_i,
  output logic             in_ready_o,
  input  wire sfr_cfg_t    cfg_i,
  input  wire logic        res_ready_i,
  output logic             res_valid_o,
  output sfr_result_t      res_o
);

  logic         hold_valid_q, hold_valid_d;
  logic [7:0]   hold_byte_q;
  logic         consume;

  parse_state_e state_q, state_d;
  logic [15:0]  topic_q, topic_d;
  logic [15:0]  left_q, left_d;
  logic [15:0]  pos_q, pos_d;
  logic [15:0]  len_q, len_d;
  logic [7:0]   sum_q, sum_d;

  logic [7:0]   b;
  logic [7:0]   sum_add;
  logic [15:0]  len_full;
  logic [15:0]  left_dec;
  logic [5:0]   recv_lim;
  logic [15:0]  recv_off;
  topic_class_e cls;
  logic [4:0]   slot;
  logic         res_hit;

  assign consume     = hold_valid_q && res_ready_i;
  assign in_ready_o  = !hold_valid_q || res_ready_i;
  assign b           = hold_byte_q;
  assign sum_add     = sum_q + b;
  assign len_full    = {b, len_q[7:0]};
  assign left_dec    = left_q - 16'd1;
  assign res_valid_o = consume && res_hit;

  // Hold the accepted byte until the parser takes it.
  always_comb begin
    hold_valid_d = hold_valid_q;
    if (in_valid_i && in_ready_o) begin
      hold_valid_d = 1'b1;
    end else if (consume) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hold_byte_q <= in_byte_i;
    end
  end

  // Classify the frame topic; receiver slots start at topic 100.
  assign recv_lim = (cfg_i.recv_count > MAX_RECEIVERS) ? MAX_RECEIVERS : cfg_i.recv_count;
  assign recv_off = topic_q - RECV_BASE;

  always_comb begin
    slot = 5'd0;
    priority if (topic_q == cfg_i.nego_topic) begin
      cls = CLS_NEGO;
    end else if (topic_q == cfg_i.time_topic) begin
      cls = CLS_TIME;
    end else if (topic_q == cfg_i.param_topic) begin
      cls = CLS_PARAM;
    end else if (topic_q >= RECV_BASE && recv_off < {10'd0, recv_lim}) begin
      cls  = CLS_RECV;
      slot = recv_off[4:0];
    end else begin
      cls = CLS_OTHER;
    end
  end

  always_comb begin
    state_d = state_q;
    topic_d = topic_q;
    left_d  = left_q;
    pos_d   = pos_q;
    len_d   = len_q;
    sum_d   = sum_add;
    res_hit = 1'b0;
    res_o   = '{kind: KIND_EVENT, data_byte: 8'd0, byte_index: 16'd0, topic: 16'd0,
                payload_length: 16'd0, status: STAT_OK, topic_class: CLS_NEGO,
                receiver_slot: 5'd0};
    unique case (state_q)
      ST_SYNC1, ST_SYNC2: begin
        if (b == SYNC_BYTE) begin
          state_d = (state_q == ST_SYNC1) ? ST_SYNC2 : ST_TOPIC_LO;
        end else begin
          state_d           = ST_SYNC1;
          sum_d             = 8'd0;
          res_hit           = 1'b1;
          res_o.status      = STAT_SYNC_ERR;
          res_o.topic_class = CLS_OTHER;
        end
      end
      ST_TOPIC_LO: begin
        sum_d   = b;
        topic_d = {8'd0, b};
        state_d = ST_TOPIC_HI;
      end
      ST_TOPIC_HI: begin
        topic_d = {b, topic_q[7:0]};
        state_d = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        len_d   = {8'd0, b};
        state_d = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        len_d  = len_full;
        left_d = len_full;
        pos_d  = 16'd0;
        if (len_full == 16'd0) begin
          state_d = ST_SUM;
        end else if (len_full <= cfg_i.max_payload) begin
          state_d = ST_PAYLOAD;
        end else begin
          // Oversize: report and restart the hunt.
          res_hit              = 1'b1;
          res_o.topic          = topic_q;
          res_o.payload_length = len_full;
          res_o.status         = STAT_TOO_BIG;
          res_o.topic_class    = cls;
          res_o.receiver_slot  = slot;
          state_d = ST_SYNC1;
          topic_d = 16'd0;
          left_d  = 16'd0;
          len_d   = 16'd0;
          sum_d   = 8'd0;
        end
      end
      ST_PAYLOAD: begin
        res_hit              = 1'b1;
        res_o.kind           = KIND_PAYLOAD;
        res_o.data_byte      = b;
        res_o.byte_index     = pos_q;
        res_o.topic          = topic_q;
        res_o.payload_length = len_q;
        pos_d  = pos_q + 16'd1;
        left_d = left_dec;
        if (left_dec == 16'd0) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        res_hit              = 1'b1;
        res_o.topic          = topic_q;
        res_o.payload_length = len_q;
        res_o.topic_class    = cls;
        res_o.receiver_slot  = slot;
        if (sum_add != SUM_GOOD) begin
          res_o.status = STAT_CSUM_BAD;
        end else if (cls == CLS_OTHER) begin
          res_o.status = STAT_UNKNOWN;
        end else begin
          res_o.status = STAT_OK;
        end
        state_d = ST_SYNC1;
        topic_d = 16'd0;
        left_d  = 16'd0;
        pos_d   = 16'd0;
        len_d   = 16'd0;
        sum_d   = 8'd0;
      end
      default: begin
        state_d = ST_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SYNC1;
      topic_q <= 16'd0;
      left_q  <= 16'd0;
      pos_q   <= 16'd0;
      len_q   <= 16'd0;
      sum_q   <= 8'd0;
    end else if (consume) begin
      state_q <= state_d;
      topic_q <= topic_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/sfr_out_buf.sv -----
// Two-entry output skid buffer for result items.
`default_nettype none

module sfr_out_buf
  import sfr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_valid_i,
  input  wire sfr_result_t push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output sfr_result_t      pop_data_o,
  input  wire logic        pop_ready_i
);

  logic        main_valid_q, main_valid_d;
  logic        skid_valid_q, skid_valid_d;
  sfr_result_t main_q, main_d;
  sfr_result_t skid_q, skid_d;
  logic        push, pop;

  assign push_ready_o = !skid_valid_q;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = main_valid_q && pop_ready_i;
  assign pop_valid_o  = main_valid_q;
  assign pop_data_o   = main_q;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        main_d = push_data_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ----- design/serial_frame_receiver_top.sv -----
// Top level of the serial frame receiver: config registers, parser, output buffer.
// Usage:
//   Feed one received serial byte per item on the s_axis channel. The block
//   hunts for frames (two 0xFF sync bytes, little-endian topic and length,
//   payload, checksum) and emits at most one result item per input byte on
//   m_axis. A result with tuser 0 is a payload byte with its index; tuser 1
//   is a frame-end or error event carrying status and topic class. Drop
//   payload bytes downstream unless the following frame-end status is ok.
//   A sync error event is produced for each byte that fails sync.
// Throughput: one byte per cycle while m_axis is not stalled; the parser update
//   is combinational logic between the input hold register and the result buffer.
// Path: an accepted byte passes the hold register, then the output buffer
//   register, before its result is on m_axis.
// Stall: when m_axis_tready_i is low the two-entry output buffer fills, the
//   hold register keeps its byte and s_axis_tready_o drops; nothing is lost.
// Reset: rst_ni clears the parser to waiting for the first sync byte and
//   loads the config registers with their defaults; no item is held.
// Config: write cfg_wdata_i to register cfg_idx_i when cfg_we_i is high;
//   write only while the block is idle.
`default_nettype none

module serial_frame_receiver_top
  import sfr_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // tdata: rx_byte[7:0]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // tdata: data_byte[7:0], byte_index[23:8], topic[39:24], payload_length[55:40],
  //        status[58:56], topic_class[61:59], receiver_slot[66:62], zero[71:67]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // tuser: kind[0]
  output logic                       m_axis_tuser_o,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  sfr_cfg_t    cfg_q, cfg_d;
  logic        res_valid, res_ready;
  sfr_result_t res, out_res;

  // Config register file; writes outside the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_PAYLOAD: cfg_d.max_payload = cfg_wdata_i;
        CFG_NEGO_TOPIC:  cfg_d.nego_topic  = cfg_wdata_i;
        CFG_TIME_TOPIC:  cfg_d.time_topic  = cfg_wdata_i;
        CFG_PARAM_TOPIC: cfg_d.param_topic = cfg_wdata_i;
        CFG_RECV_COUNT:  cfg_d.recv_count  = cfg_wdata_i[5:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_payload <= 16'd512;
      cfg_q.nego_topic  <= 16'd0;
      cfg_q.time_topic  <= 16'd10;
      cfg_q.param_topic <= 16'd6;
      cfg_q.recv_count  <= 6'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_byte_i   (s_axis_tdata_i),
    .in_ready_o  (s_axis_tready_o),
    .cfg_i       (cfg_q),
    .res_ready_i (res_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfr_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_valid),
    .push_data_i  (res),
    .push_ready_o (res_ready),
    .pop_valid_o  (m_axis_tvalid_o),
    .pop_data_o   (out_res),
    .pop_ready_i  (m_axis_tready_i)
  );

  // Pack the result fields, lowest first, and zero-fill to a byte boundary.
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tdata_o = {5'd0, out_res.receiver_slot, out_res.topic_class,
                           out_res.status, out_res.payload_length, out_res.topic,
                           out_res.byte_index, out_res.data_byte};

endmodule

`default_nettype wire

// ----- design/sfr_checker.sv -----
// Port-level assertions for the serial frame receiver, bound to the top level.
`default_nettype none

module sfr_checker
  import sfr_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic                  m_axis_tuser_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i
);

  logic [2:0] status;
  logic [2:0] cls;

  assign status = m_axis_tdata_o[58:56];
  assign cls    = m_axis_tdata_o[61:59];

  // A stalled result stays offered.
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_PAYLOAD |->
      m_axis_tdata_o[66:56] == 11'd0)
    else $error("payload item carries event fields");

  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_EVENT |-> m_axis_tdata_o[23:0] == 24'd0)
    else $error("event item carries payload fields");

  a_sync_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == KIND_EVENT && status == STAT_SYNC_ERR |->
      m_axis_tdata_o[55:24] == 32'd0 && cls == CLS_OTHER)
    else $error("sync error event with frame fields");

  a_slot_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && cls != CLS_RECV |-> m_axis_tdata_o[66:62] == 5'd0)
    else $error("receiver slot set outside receiver class");

endmodule

bind serial_frame_receiver_top sfr_checker u_sfr_checker (.*);

`default_nettype wire

// ----- tb/serial_frame_receiver_top_test.sv -----
// Self-checking testbench for the serial frame receiver: framed byte traffic against a predictor.
`timescale 1ns / 1ps

module serial_frame_receiver_top_test;
  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 4;     // hold register plus output buffer, with margin
  localparam int unsigned LONG_HOLD     = 150;
  localparam int unsigned PHASE_BYTES   = 230;

  // Frame tracker: follows the parser byte by byte and keeps the items it owes.
  class frame_tracker;
    logic [15:0]  max_payload;
    logic [15:0]  nego_topic;
    logic [15:0]  time_topic;
    logic [15:0]  param_topic;
    logic [5:0]   recv_count;

    parse_state_e state;
    logic [15:0]  frame_topic;
    logic [15:0]  bytes_left;
    logic [15:0]  payload_pos;
    logic [15:0]  frame_length;
    logic [7:0]   byte_sum;

    sfr_result_t  parser_outputs[$];
    int unsigned  mismatches;

    function new();
      max_payload = 16'd512;
      nego_topic  = 16'd0;
      time_topic  = 16'd10;
      param_topic = 16'd6;
      recv_count  = 6'd0;
      mismatches  = 0;
      restart();
    endfunction

    function void restart();
      state        = ST_SYNC1;
      frame_topic  = '0;
      bytes_left   = '0;
      payload_pos  = '0;
      frame_length = '0;
      byte_sum     = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      case (idx)
        CFG_MAX_PAYLOAD: max_payload = value;
        CFG_NEGO_TOPIC:  nego_topic  = value;
        CFG_TIME_TOPIC:  time_topic  = value;
        CFG_PARAM_TOPIC: param_topic = value;
        CFG_RECV_COUNT:  recv_count  = value[5:0];
        default: ;
      endcase
    endfunction

    // Priority: negotiation, time, parameter, then receiver slot.
    function topic_class_e classify(logic [15:0] t, output logic [4:0] slot);
      logic [5:0]  lim;
      logic [15:0] offset;
      lim    = (recv_count > MAX_RECEIVERS) ? MAX_RECEIVERS : recv_count;
      offset = t - RECV_BASE;
      slot   = '0;
      if (t == nego_topic) return CLS_NEGO;
      if (t == time_topic) return CLS_TIME;
      if (t == param_topic) return CLS_PARAM;
      if (t >= RECV_BASE && offset < {10'd0, lim}) begin
        slot = offset[4:0];
        return CLS_RECV;
      end
      return CLS_OTHER;
    endfunction

    function int unsigned outstanding();
      return parser_outputs.size();
    endfunction

    // Advance the parser by one accepted byte and note any item it produces.
    function void take_rx_byte(logic [7:0] b);
      sfr_result_t  r;
      topic_class_e cls;
      logic [4:0]   slot;
      r        = '0;
      byte_sum = byte_sum + b;
      case (state)
        ST_SYNC1, ST_SYNC2: begin
          if (b == SYNC_BYTE) begin
            if (state == ST_SYNC1) state = ST_SYNC2;
            else state = ST_TOPIC_LO;
          end else begin
            restart();
            r.kind        = KIND_EVENT;
            r.status      = STAT_SYNC_ERR;
            r.topic_class = CLS_OTHER;
            parser_outputs.push_back(r);
          end
        end
        ST_TOPIC_LO: begin
          byte_sum    = b;
          frame_topic = {8'd0, b};
          state       = ST_TOPIC_HI;
        end
        ST_TOPIC_HI: begin
          frame_topic[15:8] = b;
          state             = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          frame_length = {8'd0, b};
          state        = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          frame_length[15:8] = b;
          bytes_left         = frame_length;
          payload_pos        = '0;
          if (frame_length == 16'd0) begin
            state = ST_SUM;
          end else if (frame_length <= max_payload) begin
            state = ST_PAYLOAD;
          end else begin
            cls                = classify(frame_topic, slot);
            r.kind             = KIND_EVENT;
            r.topic            = frame_topic;
            r.payload_length   = frame_length;
            r.status           = STAT_TOO_BIG;
            r.topic_class      = cls;
            r.receiver_slot    = slot;
            parser_outputs.push_back(r);
            restart();
          end
        end
        ST_PAYLOAD: begin
          r.kind           = KIND_PAYLOAD;
          r.data_byte      = b;
          r.byte_index     = payload_pos;
          r.topic          = frame_topic;
          r.payload_length = frame_length;
          parser_outputs.push_back(r);
          payload_pos = payload_pos + 16'd1;
          bytes_left  = bytes_left - 16'd1;
          if (bytes_left == 16'd0) state = ST_SUM;
        end
        default: begin
          cls              = classify(frame_topic, slot);
          r.kind           = KIND_EVENT;
          r.topic          = frame_topic;
          r.payload_length = frame_length;
          r.topic_class    = cls;
          r.receiver_slot  = slot;
          if (byte_sum != SUM_GOOD) r.status = STAT_CSUM_BAD;
          else if (cls == CLS_OTHER) r.status = STAT_UNKNOWN;
          else r.status = STAT_OK;
          parser_outputs.push_back(r);
          restart();
        end
      endcase
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void match_output(logic [OUT_DATA_W-1:0] tdata, logic tuser);
      sfr_result_t want;
      if (parser_outputs.size() == 0) begin
        $display("%0t: unexpected item, expected none, got kind %0h tdata %h",
                 $time, tuser, tdata);
        mismatches++;
        return;
      end
      want = parser_outputs.pop_front();
      compare_field("kind",           {15'd0, want.kind},         {15'd0, tuser});
      compare_field("data_byte",      {8'd0, want.data_byte},     {8'd0, tdata[7:0]});
      compare_field("byte_index",     want.byte_index,            tdata[23:8]);
      compare_field("topic",          want.topic,                 tdata[39:24]);
      compare_field("payload_length", want.payload_length,        tdata[55:40]);
      compare_field("status",         {13'd0, want.status},       {13'd0, tdata[58:56]});
      compare_field("topic_class",    {13'd0, want.topic_class},  {13'd0, tdata[61:59]});
      compare_field("receiver_slot",  {11'd0, want.receiver_slot}, {11'd0, tdata[66:62]});
    endfunction
  endclass

  // Clock, reset and every block input start at a known value.
  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i     = '0;

  frame_tracker tracker = new();
  logic [7:0]   rx_stream[$];   // bytes waiting to be offered on the input side
  bit           hold_off_req = 1'b0;

  always #1 clk_i = ~clk_i;

  serial_frame_receiver_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Check every item taken on the output side; values are sampled as they
  // stood just before the edge, so ordering within the step does not matter.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.match_output(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // Output-side pacing: stretches of random stall patterns, including runs
  // with no stall at all. On request, hold off for a long stretch so the
  // output buffer fills and the input side has to stall.
  initial begin : sink_pacing
    int mode;
    int span;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 60);
      repeat (span) begin
        case (mode)
          0: m_axis_tready_i <= 1'b1;
          1: m_axis_tready_i <= 1'($urandom_range(0, 1));
          2: m_axis_tready_i <= ($urandom_range(0, 5) == 0);
          default: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Give up if the run stalls; the limit covers the slowest legal pacing.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("serial_frame_receiver_top_test NOT OK");
    $finish;
  end

  // Write one register; the tracker takes the new value at the same time.
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    tracker.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [15:0] max_len, input logic [15:0] nego,
                               input logic [15:0] tm, input logic [15:0] prm,
                               input logic [15:0] rcv);
    write_reg(CFG_MAX_PAYLOAD, max_len);
    write_reg(CFG_NEGO_TOPIC, nego);
    write_reg(CFG_TIME_TOPIC, tm);
    write_reg(CFG_PARAM_TOPIC, prm);
    write_reg(CFG_RECV_COUNT, rcv);
    cfg_we_i <= 1'b0;
  endtask

  // Offer one byte and hold it until the block takes it.
  task automatic send_rx_byte(input logic [7:0] b);
    s_axis_tdata_i  <= b;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.take_rx_byte(b);
  endtask

  // Drain the stream in bursts of random length with random gaps between.
  task automatic play_stream();
    int burst;
    int gap;
    burst = $urandom_range(1, 40);
    while (rx_stream.size() != 0) begin
      send_rx_byte(rx_stream.pop_front());
      burst--;
      if (burst == 0 && rx_stream.size() != 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          s_axis_tvalid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
  endtask

  // Build one frame. An oversize length stops after the header, since the
  // parser drops the frame there. A cut keeps only the first bytes.
  task automatic queue_frame(input logic [15:0] topic, input logic [15:0] len,
                             input bit sum_ok, input int cut);
    logic [7:0] frame[$];
    logic [7:0] csum;
    logic [7:0] b;
    frame = {SYNC_BYTE, SYNC_BYTE, topic[7:0], topic[15:8], len[7:0], len[15:8]};
    csum  = topic[7:0] + topic[15:8] + len[7:0] + len[15:8];
    if (len <= tracker.max_payload) begin
      repeat (len) begin
        b    = 8'($urandom_range(0, 255));
        csum = csum + b;
        frame.push_back(b);
      end
      b = SUM_GOOD - csum;
      if (!sum_ok) b = b + 8'($urandom_range(1, 255));
      frame.push_back(b);
    end
    if (cut > 0 && cut < frame.size()) frame = frame[0:cut-1];
    rx_stream = {rx_stream, frame};
  endtask

  // Favor the configured topics and the edges of the receiver slot range.
  function automatic logic [15:0] pick_topic();
    case ($urandom_range(0, 8))
      0: return tracker.nego_topic;
      1: return tracker.time_topic;
      2: return tracker.param_topic;
      3, 4: return RECV_BASE + 16'($urandom_range(0, 35));
      5: return 16'($urandom_range(96, 99));
      6: return ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Mostly short payloads; some at the limit, just over it, or far over it.
  function automatic logic [15:0] pick_length();
    logic [15:0] mx;
    logic [15:0] len;
    mx = tracker.max_payload;
    case ($urandom_range(0, 9))
      6: len = (mx <= 16'd64) ? mx : 16'($urandom_range(7, 24));
      7: len = (mx != 16'hFFFF) ? mx + 16'd1 : 16'($urandom_range(0, 3));
      8: begin
        len = 16'($urandom_range(0, 65535));
        if (len <= mx && len > 16'd64) len = {10'd0, len[5:0]};
      end
      9: len = (mx != 16'hFFFF) ? 16'hFFFF : 16'd1;
      default: len = 16'($urandom_range(0, 6));
    endcase
    return len;
  endfunction

  // Mostly whole frames with random content; the rest is line noise and cut
  // frames. Skip the noise when huge payloads are legal: a slipped header
  // could then swallow tens of thousands of bytes.
  task automatic queue_random_traffic(input int n_bytes);
    bit messy;
    int sel;
    messy = (tracker.max_payload <= 16'd1024);
    while (rx_stream.size() < n_bytes) begin
      sel = $urandom_range(0, 19);
      if (messy && sel < 2) begin
        repeat ($urandom_range(1, 3)) rx_stream.push_back(8'($urandom_range(0, 255)));
      end else if (messy && sel == 2) begin
        queue_frame(pick_topic(), pick_length(), 1'b1, $urandom_range(1, 7));
      end else begin
        queue_frame(pick_topic(), pick_length(), $urandom_range(0, 7) != 0, -1);
      end
    end
  endtask

  // Send the queued bytes, feed zeros until the parser is back to hunting,
  // then pause until every owed item has come and the pipeline is empty.
  task automatic run_phase();
    play_stream();
    while (tracker.state != ST_SYNC1) send_rx_byte(8'h00);
    s_axis_tvalid_i <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at reset settings: two bad first sync bytes, a bad
    // second sync byte, an empty frame on the time topic, a one-byte
    // negotiation frame with a bad checksum and an oversize frame.
    rx_stream = {8'h00, 8'h7E, SYNC_BYTE, 8'h55};
    queue_frame(16'd10, 16'd0, 1'b1, -1);
    queue_frame(16'd0, 16'd1, 1'b0, -1);
    queue_frame(RECV_BASE, 16'd513, 1'b1, -1);
    queue_random_traffic(PHASE_BYTES);
    run_phase();

    // Walk through settings, extremes included. The first one also runs
    // with a long output-side hold while bytes keep coming.
    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: apply_setting(16'd1, 16'hFFFF, 16'd0, RECV_BASE, 16'd32);
        2: apply_setting(16'hFFFF, 16'd5, 16'd5, 16'd5, 16'd0);
        3: apply_setting(16'd16, 16'd200, 16'd300, 16'd101, 16'd40);
        4: apply_setting(16'd0, 16'd0, 16'd1, 16'd2, 16'd1);
        default: apply_setting(16'd300, 16'd1234, 16'hFFFF, 16'd0, 16'd31);
      endcase
      if (phase == 1) hold_off_req = 1'b1;
      if (phase == 5) queue_frame(pick_topic(), tracker.max_payload, 1'b1, -1);
      queue_random_traffic(PHASE_BYTES);
      run_phase();
    end

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("serial_frame_receiver_top_test OK");
    end else begin
      $display("serial_frame_receiver_top_test NOT OK");
    end
    $finish;
  end

endmodule
